// File: rtl/sstg_pkg.sv
// types and constants shared by the step timing generator
package sstg_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_SHIFT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_PENDING  = 2'd0,
    STAT_COMPLETE = 2'd1,
    STAT_ABORT    = 2'd2
  } status_e;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_SWAP = 1'b0,
    CFG_END_EN   = 1'b1
  } cfg_e;

  localparam int unsigned DIV_W = 32;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned MUL_P_W = 64;
  localparam int unsigned MUL_CNT_W = 5;
  localparam int unsigned X_W = 18;

  localparam logic [X_W-1:0] RAMP_SPAN = 18'd200000;
  localparam logic [31:0] RAMP_BASE = 32'd200000;
  localparam logic [4:0] RAMP_GAIN = 5'd29;
  localparam logic [31:0] RAMP_NUM = 32'd240000000;
  localparam logic [31:0] DELAY_MAX = 32'h7fff_ffff;
  localparam logic [30:0] LEN_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] step_count;
    logic [30:0]        time_value;
    logic               end_hit;
  } req_t;

  typedef struct packed {
    logic signed [31:0] next_delay;
    logic [1:0]         status;
    logic               step_level;
    logic               dir_level;
    logic               realign_pulse;
    logic signed [31:0] position;
    logic signed [31:0] remaining;
    logic [30:0]        done_count;
  } rsp_t;

endpackage

// File: rtl/sstg_div.sv
// restoring divider, one quotient bit per cycle
module sstg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sstg_pkg::DIV_W-1:0]  dividend_i,
  input  logic [sstg_pkg::DIV_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [sstg_pkg::DIV_W-1:0]  quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [sstg_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [sstg_pkg::DIV_W-1:0]     rem_q, rem_d;
  logic [sstg_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [sstg_pkg::DIV_W-1:0]     dvs_q, dvs_d;
  logic [sstg_pkg::DIV_W:0]       trial;
  logic [sstg_pkg::DIV_W:0]       diff;
  logic                           fits;

  assign trial = {rem_q, quo_q[sstg_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sstg_pkg::DIV_CNT_W'(sstg_pkg::DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[sstg_pkg::DIV_W-1:0] : trial[sstg_pkg::DIV_W-1:0];
      quo_d = {quo_q[sstg_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sstg_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/sstg_mul.sv
// shift and add multiplier, one multiplier bit per cycle
module sstg_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sstg_pkg::MUL_A_W-1:0]  a_i,
  input  logic [sstg_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [sstg_pkg::MUL_P_W-1:0]  product_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [sstg_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [sstg_pkg::MUL_A_W-1:0]   a_q, a_d;
  logic [sstg_pkg::MUL_A_W-1:0]   hi_q, hi_d;
  logic [sstg_pkg::MUL_B_W-1:0]   lo_q, lo_d;
  logic [sstg_pkg::MUL_A_W:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sstg_pkg::MUL_CNT_W'(sstg_pkg::MUL_B_W);
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = sum[sstg_pkg::MUL_A_W:1];
      lo_d  = {sum[0], lo_q[sstg_pkg::MUL_B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sstg_pkg::MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

// File: rtl/stepper_step_timing_generator.sv
// step timing generator for one stepper axis with a linear speed ramp
//
//   channel   direction  handshake              payload
//   req       in         req_valid_i/req_ready_o sstg_pkg::req_t
//   rsp       out        rsp_valid_o/rsp_ready_i sstg_pkg::rsp_t
//   cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// one request at a time; shift, abort and unused commands go straight to the result state
// a timed step waits on the bit serial multiplier
// a ramp step waits on the bit serial divider
// a start with a nonzero count runs the interval divide, then the first delay
// the result register frees the input side while a response is stalled
// reset is asynchronous, active low, and clears all axis state
module stepper_step_timing_generator #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  sstg_pkg::req_t                    req_i,
  output logic                              rsp_valid_o,
  input  logic                              rsp_ready_i,
  output sstg_pkg::rsp_t                    rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sstg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sstg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_IDIV = 7'b0000010,
    S_NEXT = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_RAMP = 7'b0010000,
    S_RDIV = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e                       state_q, state_d;
  logic                         swap_q, swap_d;
  logic                         end_en_q, end_en_d;
  logic signed [POS_WIDTH-1:0]  pos_q, pos_d;
  logic                         dir_set_q, dir_set_d;
  logic                         dir_neg_q, dir_neg_d;
  logic                         pin_q, pin_d;
  logic [30:0]                  length_q, length_d;
  logic [31:0]                  index_q, index_d;
  logic [30:0]                  duration_q, duration_d;
  logic [30:0]                  interval_q, interval_d;
  logic [30:0]                  decel_time_q, decel_time_d;
  logic [31:0]                  decel_dist_q, decel_dist_d;
  logic                         rsp_valid_q, rsp_valid_d;

  logic signed [31:0]           delay_q, delay_d;
  sstg_pkg::status_e            status_q, status_d;
  logic                         realign_q, realign_d;
  logic [30:0]                  t_q, t_d;
  logic [sstg_pkg::X_W-1:0]     x_q, x_d;
  sstg_pkg::rsp_t               rsp_q, rsp_d;

  logic                         req_fire;
  logic                         s_neg;
  logic [31:0]                  s_mag;
  logic [30:0]                  s_len;
  logic                         d_neg;
  logic [32:0]                  x_raw;
  logic [sstg_pkg::X_W-1:0]     x_clamp;
  logic [31:0]                  ramp_den;
  logic [32:0]                  rem_raw;
  logic signed [31:0]           rem_sat;
  logic [30:0]                  done_cnt;
  logic [sstg_pkg::MUL_P_W:0]   late_diff;
  logic signed [31:0]           timed_delay;

  logic                         div_start;
  logic [sstg_pkg::DIV_W-1:0]   div_dividend;
  logic [sstg_pkg::DIV_W-1:0]   div_divisor;
  logic                         div_done;
  logic [sstg_pkg::DIV_W-1:0]   div_quot;
  logic                         mul_start;
  logic                         mul_done;
  logic [sstg_pkg::MUL_P_W-1:0] mul_prod;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;

  // start: magnitude of the step count, saturated to 31 bits
  assign s_neg = req_i.step_count[31];
  assign s_mag = s_neg ? (32'd0 - req_i.step_count) : req_i.step_count;
  assign s_len = s_mag[31] ? sstg_pkg::LEN_MAX : s_mag[30:0];
  assign d_neg = swap_q ^ s_neg;

  // deceleration position on the ramp, clamped to the span
  assign x_raw = {2'b00, decel_time_q} + {2'b00, interval_q} - {2'b00, t_q};
  always_comb begin
    if (x_raw[32]) begin
      x_clamp = '0;
    end else if (x_raw[31:0] > 32'(sstg_pkg::RAMP_SPAN)) begin
      x_clamp = sstg_pkg::RAMP_SPAN;
    end else begin
      x_clamp = x_raw[sstg_pkg::X_W-1:0];
    end
  end

  assign ramp_den = sstg_pkg::RAMP_BASE + 32'(x_q) * 32'(sstg_pkg::RAMP_GAIN);

  // timed mode: (index + 1) * interval - elapsed, saturated
  assign late_diff   = {1'b0, mul_prod} - (sstg_pkg::MUL_P_W + 1)'(t_q);
  assign timed_delay = (!late_diff[sstg_pkg::MUL_P_W] && (late_diff[63:31] != '0)) ?
                       sstg_pkg::DELAY_MAX : late_diff[31:0];

  assign rem_raw  = {2'b00, length_q} - {1'b0, index_q};
  assign rem_sat  = (rem_raw[32] && !rem_raw[31]) ? 32'h8000_0000 : rem_raw[31:0];
  assign done_cnt = index_q[31] ? sstg_pkg::LEN_MAX : index_q[30:0];

  assign div_start    = (req_fire && (req_i.cmd == sstg_pkg::CMD_START) && (s_len != '0)) ||
                        (state_q == S_RAMP);
  assign div_dividend = (state_q == S_RAMP) ? sstg_pkg::RAMP_NUM : {1'b0, req_i.time_value};
  assign div_divisor  = (state_q == S_RAMP) ? ramp_den : {1'b0, s_len};

  always_comb begin
    swap_d   = swap_q;
    end_en_d = end_en_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sstg_pkg::CFG_DIR_SWAP: swap_d   = cfg_data_i[0];
        sstg_pkg::CFG_END_EN:   end_en_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    dir_set_d    = dir_set_q;
    dir_neg_d    = dir_neg_q;
    pin_d        = pin_q;
    length_d     = length_q;
    index_d      = index_q;
    duration_d   = duration_q;
    interval_d   = interval_q;
    decel_time_d = decel_time_q;
    decel_dist_d = decel_dist_q;
    delay_d      = delay_q;
    status_d     = status_q;
    realign_d    = realign_q;
    t_d          = t_q;
    x_d          = x_q;
    mul_start    = 1'b0;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_d        = rsp_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          realign_d = 1'b0;
          delay_d   = '0;
          status_d  = sstg_pkg::STAT_PENDING;
          state_d   = S_FIN;
          case (req_i.cmd)
            sstg_pkg::CMD_START: begin
              index_d      = '0;
              length_d     = s_len;
              duration_d   = req_i.time_value;
              decel_time_d = '0;
              decel_dist_d = {1'b0, s_len};
              t_d          = '0;
              if (s_len != '0) begin
                if (!dir_set_q || (dir_neg_q != d_neg)) begin
                  dir_set_d = 1'b1;
                  dir_neg_d = d_neg;
                  realign_d = pin_q;
                end
                state_d = S_IDIV;
              end else begin
                interval_d = '0;
                state_d    = S_NEXT;
              end
            end
            sstg_pkg::CMD_STEP: begin
              if (end_en_q && req_i.end_hit) begin
                dir_neg_d = ~dir_neg_q;
                delay_d   = '1;
                status_d  = sstg_pkg::STAT_ABORT;
              end else begin
                if (dir_set_q) begin
                  pos_d = dir_neg_q ? pos_q - POS_WIDTH'(1) : pos_q + POS_WIDTH'(1);
                end
                pin_d   = ~pin_q;
                index_d = (index_q == '1) ? index_q : index_q + 32'd1;
                t_d     = req_i.time_value;
                state_d = S_NEXT;
              end
            end
            sstg_pkg::CMD_SHIFT: begin
              pos_d = pos_q + POS_WIDTH'(req_i.step_count);
            end
            default: ;
          endcase
        end
      end
      S_IDIV: begin
        if (div_done) begin
          interval_d = div_quot[30:0];
          state_d    = S_NEXT;
        end
      end
      S_NEXT: begin
        status_d = sstg_pkg::STAT_PENDING;
        if (index_q >= {1'b0, length_q}) begin
          delay_d  = '1;
          status_d = sstg_pkg::STAT_COMPLETE;
          state_d  = S_FIN;
        end else if (duration_q != '0) begin
          mul_start = 1'b1;
          state_d   = S_MUL;
        end else if (index_q > decel_dist_q) begin
          x_d     = x_clamp;
          state_d = S_RAMP;
        end else if (t_q < 31'(sstg_pkg::RAMP_SPAN)) begin
          decel_time_d = t_q;
          decel_dist_d = {1'b0, length_q} - index_q;
          interval_d   = t_q;
          x_d          = t_q[sstg_pkg::X_W-1:0];
          state_d      = S_RAMP;
        end else begin
          decel_time_d = t_q;
          x_d          = sstg_pkg::RAMP_SPAN;
          state_d      = S_RAMP;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          delay_d = timed_delay;
          state_d = S_FIN;
        end
      end
      S_RAMP: begin
        state_d = S_RDIV;
      end
      S_RDIV: begin
        if (div_done) begin
          delay_d = div_quot;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d         = 1'b1;
          rsp_d.next_delay    = delay_q;
          rsp_d.status        = status_q;
          rsp_d.step_level    = pin_q;
          rsp_d.dir_level     = ~(dir_set_q & dir_neg_q);
          rsp_d.realign_pulse = realign_q;
          rsp_d.position      = 32'(pos_q);
          rsp_d.remaining     = rem_sat;
          rsp_d.done_count    = done_cnt;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  sstg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  sstg_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       ({1'b0, index_q} + 33'd1),
    .b_i       (interval_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      swap_q       <= 1'b0;
      end_en_q     <= 1'b1;
      pos_q        <= '0;
      dir_set_q    <= 1'b0;
      dir_neg_q    <= 1'b0;
      pin_q        <= 1'b0;
      length_q     <= '0;
      index_q      <= '0;
      duration_q   <= '0;
      interval_q   <= '0;
      decel_time_q <= '0;
      decel_dist_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      swap_q       <= swap_d;
      end_en_q     <= end_en_d;
      pos_q        <= pos_d;
      dir_set_q    <= dir_set_d;
      dir_neg_q    <= dir_neg_d;
      pin_q        <= pin_d;
      length_q     <= length_d;
      index_q      <= index_d;
      duration_q   <= duration_d;
      interval_q   <= interval_d;
      decel_time_q <= decel_time_d;
      decel_dist_q <= decel_dist_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delay_q   <= delay_d;
    status_q  <= status_d;
    realign_q <= realign_d;
    t_q       <= t_d;
    x_q       <= x_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/sstg_chk.sv
// port checker for the step timing generator, bound to the top level
module sstg_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input sstg_pkg::rsp_t rsp_i
);

  // one request in flight: ready drops after an accepted request
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one still in work");

  // complete and abort always report a delay of minus one
  a_end_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == sstg_pkg::STAT_COMPLETE ||
                    rsp_i.status == sstg_pkg::STAT_ABORT)
    |-> rsp_i.next_delay == -32'sd1)
    else $error("end of move without minus one delay");

  // a realign pulse only goes out while the step level is high
  a_realign_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.realign_pulse |-> rsp_i.step_level)
    else $error("realign pulse with step level low");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled response changed");

endmodule

bind stepper_step_timing_generator sstg_chk u_sstg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_i (req_ready_o),
  .rsp_valid_i (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_i       (rsp_o)
);

// File: bench/tb_stepper_step_timing_generator.sv
// testbench for the step timing generator: random and directed requests checked against a predictor
`timescale 1ns / 1ps

module tb_stepper_step_timing_generator;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_REQS = 680;
  localparam longint RAMP_SPAN_L = 200_000;
  localparam longint RAMP_NUM_L = 240_000_000;
  localparam longint RAMP_GAIN_L = 29;
  localparam longint LEN_CAP = 'h7fff_ffff;
  localparam longint IDX_CAP = 'hffff_ffff;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    sstg_pkg::req_t req;
    bit             drain;
  } req_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready_o;
  sstg_pkg::req_t req = '0;
  logic rsp_valid_o;
  logic rsp_ready = 1'b0;
  sstg_pkg::rsp_t rsp_o;
  logic cfg_we = 1'b0;
  logic [sstg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [sstg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  req_entry_t move_req_q[$];
  sstg_pkg::rsp_t rsp_due_q[$];
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned n_queued = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  bit drain_next = 1'b0;

  // axis state as the predictor sees it
  bit swap_cfg = 1'b0;
  bit endstop_cfg = 1'b1;
  logic [31:0] pos_q = '0;
  int dir_q = 0;
  logic pin_q = 1'b0;
  longint len_q = 0;
  longint idx_q = 0;
  longint dur_q = 0;
  longint ivl_q = 0;
  longint dtime_q = 0;
  longint ddist_q = 0;

  stepper_step_timing_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready_o),
    .req_i       (req),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint clamp32(input longint v);
    if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint ramp_wait(input longint x);
    if (x < 0) x = 0;
    if (x > RAMP_SPAN_L) x = RAMP_SPAN_L;
    return RAMP_NUM_L / (RAMP_SPAN_L + RAMP_GAIN_L * x);
  endfunction

  function automatic longint next_wait(input longint t, output bit fin);
    fin = 1'b0;
    if (idx_q >= len_q) begin
      fin = 1'b1;
      return -1;
    end
    if (dur_q != 0) return clamp32((idx_q + 1) * ivl_q - t);
    if (idx_q > ddist_q) return ramp_wait(dtime_q + ivl_q - t);
    if (t < RAMP_SPAN_L) begin
      dtime_q = t;
      ddist_q = len_q - idx_q;
      ivl_q = t;
      return ramp_wait(t);
    end
    dtime_q = t;
    return ramp_wait(RAMP_SPAN_L);
  endfunction

  function automatic sstg_pkg::rsp_t axis_response(input sstg_pkg::req_t r);
    sstg_pkg::rsp_t o;
    longint s;
    longint delay;
    longint rem;
    int d;
    bit fin;
    logic realign;
    o = '0;
    delay = 0;
    realign = 1'b0;
    o.status = sstg_pkg::STAT_PENDING;
    case (r.cmd)
      sstg_pkg::CMD_START: begin
        d = swap_cfg ? -1 : 1;
        s = {{32{r.step_count[31]}}, r.step_count};
        if (s < 0) begin
          d = -d;
          s = -s;
        end
        if (s > LEN_CAP) s = LEN_CAP;
        idx_q = 0;
        len_q = s;
        dur_q = longint'(r.time_value);
        dtime_q = 0;
        ddist_q = len_q;
        if (s > 0) begin
          ivl_q = dur_q / s;
          if (dir_q != d) begin
            dir_q = d;
            realign = pin_q;
          end
        end else begin
          ivl_q = 0;
        end
        delay = next_wait(0, fin);
        o.status = fin ? sstg_pkg::STAT_COMPLETE : sstg_pkg::STAT_PENDING;
      end
      sstg_pkg::CMD_STEP: begin
        if (endstop_cfg && r.end_hit) begin
          dir_q = -dir_q;
          delay = -1;
          o.status = sstg_pkg::STAT_ABORT;
        end else begin
          pos_q = pos_q + 32'(dir_q);
          pin_q = ~pin_q;
          if (idx_q != IDX_CAP) idx_q++;
          delay = next_wait(longint'(r.time_value), fin);
          o.status = fin ? sstg_pkg::STAT_COMPLETE : sstg_pkg::STAT_PENDING;
        end
      end
      sstg_pkg::CMD_SHIFT: pos_q = pos_q + r.step_count;
      default: ;
    endcase
    rem = clamp32(len_q - idx_q);
    o.next_delay = delay[31:0];
    o.step_level = pin_q;
    o.dir_level = (dir_q >= 0);
    o.realign_pulse = realign;
    o.position = pos_q;
    o.remaining = rem[31:0];
    o.done_count = (idx_q > LEN_CAP) ? 31'h7fff_ffff : idx_q[30:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic cfg_write(input sstg_pkg::cfg_e idx, input bit val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == sstg_pkg::CFG_DIR_SWAP) swap_cfg = val;
    else endstop_cfg = val;
  endtask

  task automatic queue_req(input logic [1:0] cmd, input logic [31:0] cnt,
                           input logic [30:0] tv, input logic hit);
    req_entry_t e;
    e.req.cmd = cmd;
    e.req.step_count = cnt;
    e.req.time_value = tv;
    e.req.end_hit = hit;
    e.drain = drain_next || ($urandom_range(199) == 0);
    drain_next = 1'b0;
    move_req_q.push_back(e);
    n_queued++;
  endtask

  // a start followed by step events with mostly rising elapsed time and occasional shifts
  task automatic gen_move();
    longint mag;
    longint t;
    longint gap;
    logic [31:0] cnt;
    logic [30:0] dur;
    int unsigned pick;
    int unsigned n_ev;
    pick = $urandom_range(9);
    if (pick == 0) mag = 0;
    else if (pick == 1) mag = longint'($urandom_range(32'h7fff_ffff, 11));
    else mag = longint'($urandom_range(10, 1));
    cnt = $urandom_range(1) ? -mag[31:0] : mag[31:0];
    pick = $urandom_range(19);
    if (pick < 10) dur = '0;
    else if (pick < 17) dur = 31'($urandom_range(2_000_000, 1));
    else dur = 31'($urandom);
    queue_req(sstg_pkg::CMD_START, cnt, dur, 1'($urandom_range(1)));
    n_ev = 32'(mag > 10 ? 10 : mag) + $urandom_range(2);
    gap = (dur == 0) ? 0 : longint'(dur) / (mag == 0 ? 1 : mag);
    t = 0;
    repeat (n_ev) begin
      if (dur == 0) t += longint'($urandom_range(80_000));
      else t += gap / 2 + longint'($urandom_range(32'(gap)));
      if ($urandom_range(31) == 0) t = longint'($urandom_range(32'h7fff_ffff));
      if (t > LEN_CAP) t = LEN_CAP;
      if ($urandom_range(15) == 0)
        queue_req(sstg_pkg::CMD_SHIFT, $urandom, 31'($urandom),
                  1'($urandom_range(1)));
      queue_req(sstg_pkg::CMD_STEP, $urandom, t[30:0], $urandom_range(19) == 0);
    end
  endtask

  task automatic wait_idle();
    while (move_req_q.size() != 0 || n_taken != n_sent || rsp_due_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    if (rst_ni && n_taken == n_sent) begin
      if (move_req_q.size() != 0 && !(move_req_q[0].drain && rsp_due_q.size() != 0)
          && $urandom_range(99) >= send_idle_pct) begin
        req <= move_req_q[0].req;
        void'(move_req_q.pop_front());
        n_sent++;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin : monitor_blk
    sstg_pkg::rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready) begin
        if (rsp_due_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          want = rsp_due_q.pop_front();
          check_field("next_delay", want.next_delay, rsp_o.next_delay);
          check_field("status", 32'(want.status), 32'(rsp_o.status));
          check_field("step_level", 32'(want.step_level), 32'(rsp_o.step_level));
          check_field("dir_level", 32'(want.dir_level), 32'(rsp_o.dir_level));
          check_field("realign_pulse", 32'(want.realign_pulse),
                      32'(rsp_o.realign_pulse));
          check_field("position", want.position, rsp_o.position);
          check_field("remaining", want.remaining, rsp_o.remaining);
          check_field("done_count", 32'(want.done_count), 32'(rsp_o.done_count));
        end
      end
      if (req_valid && req_ready_o) begin
        rsp_due_q.push_back(axis_response(req));
        n_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 63 : 0;
      rcv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 19 : 0;
      cfg_write(sstg_pkg::CFG_DIR_SWAP, ph != 0);
      cfg_write(sstg_pkg::CFG_END_EN, ph != 1);
      if (ph == 0) begin
        // step with no direction, then an abort with no direction
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd0, 1'b1);
        queue_req(sstg_pkg::CMD_SHIFT, 32'h7fff_ffff, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_SHIFT, 32'h8000_0000, 31'd0, 1'b0);
        queue_req(CMD_UNUSED, 32'hffff_ffff, 31'h7fff_ffff, 1'b1);
        queue_req(sstg_pkg::CMD_START, 32'd0, 31'd5, 1'b0);
        // most negative count in ramp mode, step high so a realign pulse
        queue_req(sstg_pkg::CMD_START, 32'h8000_0000, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd199_999, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd200_000, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'h7fff_ffff, 1'b0);
        // short ramp through acceleration, deceleration and completion
        queue_req(sstg_pkg::CMD_START, 32'd4, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd1000, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd2000, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd3000, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd4000, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd5000, 1'b0);
        // timed move with the longest duration, then a late step
        queue_req(sstg_pkg::CMD_START, 32'd3, 31'h7fff_ffff, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd0, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'h7fff_ffff, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd0, 1'b1);
        queue_req(sstg_pkg::CMD_START, 32'd2, 31'd100, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd40, 1'b0);
        queue_req(sstg_pkg::CMD_STEP, 32'd0, 31'd100, 1'b0);
      end
      drain_next = 1'b1;
      n_queued = 0;
      while (n_queued < PHASE_REQS) begin
        if ($urandom_range(99) < 8)
          queue_req(2'($urandom_range(3)), $urandom, 31'($urandom),
                    1'($urandom_range(1)));
        else
          gen_move();
      end
      wait_idle();
    end
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
